// File: rtl/gha_pkg.sv
// Shared types, codes and a helper function for the generational handle allocator.
package gha_pkg;

  // Fixed widths of the transaction fields.
  localparam int OPCODE_W    = 2;
  localparam int IDX_FIELD_W = 10;
  localparam int VER_FIELD_W = 16;
  localparam int STATUS_W    = 2;

  // Widest vector that the highest-bit search handles, and its index width.
  localparam int SCAN_W     = 256;
  localparam int SCAN_IDX_W = 8;

  // Operation codes.
  localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CHECK   = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]    opcode;
    logic [IDX_FIELD_W-1:0] slot_index;
    logic [VER_FIELD_W-1:0] slot_version;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [IDX_FIELD_W-1:0] handle_index;
    logic [VER_FIELD_W-1:0] handle_version;
    logic                   handle_valid;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COL,
    ST_FIN
  } state_t;

  // Position of the highest set bit; zero when no bit is set.
  function automatic logic [SCAN_IDX_W-1:0] top_one(input logic [SCAN_W-1:0] v);
    logic [SCAN_IDX_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < SCAN_W; i++) begin
      if (v[i]) begin
        pos = SCAN_IDX_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

// File: rtl/gha_free_map.sv
// Two-level free bitmap: a row memory of free bits plus a per-row summary register.
module gha_free_map #(
  parameter int ROW_W = 5,
  parameter int COL_W = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [ROW_W-1:0]      rd_row,
  output logic [(2**COL_W)-1:0] rd_bits,
  input  logic                  wr_en,
  input  logic [ROW_W-1:0]      wr_row,
  input  logic [(2**COL_W)-1:0] wr_bits,
  output logic [ROW_W-1:0]      top_row,
  output logic                  any_free
);

  localparam int ROWS = 2**ROW_W;
  localparam int COLS = 2**COL_W;

  logic [COLS-1:0] mem [ROWS];
  logic [COLS-1:0] mem_q;
  logic [ROWS-1:0] row_vld;
  logic [ROWS-1:0] summary;
  logic            vld_q;

  // Row memory with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_bits;
    end
    if (rd_en) begin
      mem_q <= mem[rd_row];
    end
  end

  // Row valid bits and the summary of rows that hold a free slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      summary <= '0;
      vld_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld[wr_row] <= 1'b1;
        summary[wr_row] <= |wr_bits;
      end
      if (rd_en) begin
        vld_q <= row_vld[rd_row];
      end
    end
  end

  // A row never written since reset reads as all clear.
  assign rd_bits  = vld_q ? mem_q : '0;
  assign any_free = |summary;
  assign top_row  = ROW_W'(gha_pkg::top_one(gha_pkg::SCAN_W'(summary)));

endmodule

// File: rtl/generational_handle_allocator_core.sv
// Release, check and fresh allocate go from idle to the final state, which registers the
// result once the output is not stalled; an allocate that reuses a freed slot first passes
// the column state (row read, then version read). A new transaction is accepted only back in
// idle, set by the serialized read-modify-write of the version and free-bit row memories.
// Reset clears the high-water count, the free-map summary and row valid bits at once;
// there is no clearing pass, and the block accepts transactions in the first cycle after.
module generational_handle_allocator_core #(
  parameter int SLOT_COUNT   = 1024,
  parameter int VERSION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  gha_pkg::request_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output gha_pkg::result_t  out_data
);

  localparam int IW     = (SLOT_COUNT > 4) ? $clog2(SLOT_COUNT) : 2;
  localparam int COL_W  = IW / 2;
  localparam int ROW_W  = IW - COL_W;
  localparam int COLS   = 2**COL_W;
  localparam int DEPTH  = 2**IW;
  localparam int HW_W   = $clog2(SLOT_COUNT + 1);
  localparam int CMP_W  = (HW_W > gha_pkg::IDX_FIELD_W) ? HW_W : gha_pkg::IDX_FIELD_W;
  localparam int VCMP_W = (VERSION_BITS > gha_pkg::VER_FIELD_W) ? VERSION_BITS
                                                                 : gha_pkg::VER_FIELD_W;

  gha_pkg::state_t state, state_next;

  // Registered request.
  logic [gha_pkg::OPCODE_W-1:0]    req_op;
  logic [gha_pkg::IDX_FIELD_W-1:0] req_idx;
  logic [gha_pkg::VER_FIELD_W-1:0] req_ver;
  logic                            req_opened;
  logic                            req_reuse;
  logic [ROW_W-1:0]                row_sel;
  logic [COL_W-1:0]                col_sel;
  logic [HW_W-1:0]                 hw;

  // Version memory.
  logic [VERSION_BITS-1:0] ver_mem [DEPTH];
  logic [VERSION_BITS-1:0] ver_q;
  logic                    ver_re;
  logic [IW-1:0]           ver_ra;
  logic                    ver_we;
  logic [IW-1:0]           ver_wa;
  logic [VERSION_BITS-1:0] ver_wd;

  // Free map connections.
  logic             fm_rd_en;
  logic [ROW_W-1:0] fm_rd_row;
  logic [COLS-1:0]  fm_rd_bits;
  logic             fm_wr_en;
  logic [COLS-1:0]  fm_wr_bits;
  logic [ROW_W-1:0] fm_top_row;
  logic             fm_any;

  logic                    accept;
  logic                    out_go;
  logic                    fin_go;
  logic                    hw_inc;
  logic [IW-1:0]           in_addr;
  logic [COL_W-1:0]        col_top;
  logic [VERSION_BITS-1:0] stored;
  logic                    match;
  logic                    is_free;
  logic [COLS-1:0]         col_bit;
  logic                    in_opened;
  gha_pkg::result_t        result_next;

  assign in_stall  = (state != gha_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_go    = !out_valid || !out_stall;
  assign fin_go    = (state == gha_pkg::ST_FIN) && out_go;
  assign in_addr   = IW'(in_data.slot_index);
  assign in_opened = CMP_W'(in_data.slot_index) < CMP_W'(hw);
  assign col_top   = COL_W'(gha_pkg::top_one(gha_pkg::SCAN_W'(fm_rd_bits)));
  assign col_bit   = COLS'(1) << col_sel;

  // Values judged from the slot as it was before this transaction.
  assign stored  = req_opened ? ver_q : '0;
  assign match   = req_opened && (VCMP_W'(stored) == VCMP_W'(req_ver));
  assign is_free = fm_rd_bits[col_sel];

  gha_free_map #(
    .ROW_W(ROW_W),
    .COL_W(COL_W)
  ) u_free_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (fm_rd_en),
    .rd_row  (fm_rd_row),
    .rd_bits (fm_rd_bits),
    .wr_en   (fm_wr_en),
    .wr_row  (row_sel),
    .wr_bits (fm_wr_bits),
    .top_row (fm_top_row),
    .any_free(fm_any)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      gha_pkg::ST_IDLE: begin
        if (accept) begin
          if ((in_data.opcode == gha_pkg::OP_ALLOC) && fm_any) begin
            state_next = gha_pkg::ST_COL;
          end else begin
            state_next = gha_pkg::ST_FIN;
          end
        end
      end
      gha_pkg::ST_COL: state_next = gha_pkg::ST_FIN;
      gha_pkg::ST_FIN: begin
        if (out_go) begin
          state_next = gha_pkg::ST_IDLE;
        end
      end
      default: state_next = gha_pkg::ST_IDLE;
    endcase
  end

  // Memory reads issued per state.
  always_comb begin
    fm_rd_en  = 1'b0;
    fm_rd_row = in_addr[IW-1:COL_W];
    ver_re    = 1'b0;
    ver_ra    = in_addr;
    unique case (state)
      gha_pkg::ST_IDLE: begin
        if (in_data.opcode == gha_pkg::OP_ALLOC) begin
          fm_rd_en  = accept && fm_any;
          fm_rd_row = fm_top_row;
        end else begin
          fm_rd_en = accept;
          ver_re   = accept;
        end
      end
      gha_pkg::ST_COL: begin
        ver_re = 1'b1;
        ver_ra = {row_sel, col_top};
      end
      default: begin
        fm_rd_en = 1'b0;
        ver_re   = 1'b0;
      end
    endcase
  end

  // Result and write-back in the final state.
  always_comb begin
    result_next = '0;
    fm_wr_en    = 1'b0;
    fm_wr_bits  = fm_rd_bits;
    ver_we      = 1'b0;
    ver_wa      = IW'(req_idx);
    ver_wd      = stored + VERSION_BITS'(1);
    hw_inc      = 1'b0;
    unique case (req_op)
      gha_pkg::OP_ALLOC: begin
        if (req_reuse) begin
          result_next.status         = gha_pkg::STATUS_OK;
          result_next.handle_index   = gha_pkg::IDX_FIELD_W'({row_sel, col_sel});
          result_next.handle_version = gha_pkg::VER_FIELD_W'(ver_q);
          result_next.handle_valid   = 1'b1;
          fm_wr_en                   = fin_go;
          fm_wr_bits                 = fm_rd_bits & ~col_bit;
        end else if (hw < HW_W'(SLOT_COUNT)) begin
          // Open the next fresh slot at version zero.
          result_next.status       = gha_pkg::STATUS_OK;
          result_next.handle_index = gha_pkg::IDX_FIELD_W'(hw);
          result_next.handle_valid = 1'b1;
          ver_we                   = fin_go;
          ver_wa                   = IW'(hw);
          ver_wd                   = '0;
          hw_inc                   = fin_go;
        end else begin
          result_next.status = gha_pkg::STATUS_FULL;
        end
      end
      gha_pkg::OP_RELEASE: begin
        result_next.handle_index   = req_idx;
        result_next.handle_version = gha_pkg::VER_FIELD_W'(stored);
        result_next.handle_valid   = match;
        if (!match || is_free) begin
          result_next.status = gha_pkg::STATUS_BAD;
        end else begin
          // Bump the version and mark the slot free.
          result_next.status = gha_pkg::STATUS_OK;
          ver_we             = fin_go;
          fm_wr_en           = fin_go;
          fm_wr_bits         = fm_rd_bits | col_bit;
        end
      end
      gha_pkg::OP_CHECK: begin
        result_next.status         = gha_pkg::STATUS_OK;
        result_next.handle_index   = req_idx;
        result_next.handle_version = gha_pkg::VER_FIELD_W'(stored);
        result_next.handle_valid   = match;
      end
      default: begin
        result_next.status         = gha_pkg::STATUS_BAD;
        result_next.handle_index   = req_idx;
        result_next.handle_version = gha_pkg::VER_FIELD_W'(stored);
        result_next.handle_valid   = match;
      end
    endcase
  end

  // Version memory with a registered read port.
  always_ff @(posedge clk) begin
    if (ver_we) begin
      ver_mem[ver_wa] <= ver_wd;
    end
    if (ver_re) begin
      ver_q <= ver_mem[ver_ra];
    end
  end

  // Request capture and slot selection.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_op     <= in_data.opcode;
      req_idx    <= in_data.slot_index;
      req_ver    <= in_data.slot_version;
      req_opened <= in_opened;
      req_reuse  <= fm_any;
      if (in_data.opcode == gha_pkg::OP_ALLOC) begin
        row_sel <= fm_top_row;
      end else begin
        row_sel <= in_addr[IW-1:COL_W];
        col_sel <= in_addr[COL_W-1:0];
      end
    end else if (state == gha_pkg::ST_COL) begin
      col_sel <= col_top;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_data <= result_next;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gha_pkg::ST_IDLE;
      hw        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (hw_inc) begin
        hw <= hw + HW_W'(1);
      end
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/gha_checker.sv
// Port-level checker for the generational handle allocator, bound to the top level.
module gha_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input gha_pkg::result_t out_data
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // The block works on one transaction at a time, so it is busy right after an accept.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous transaction in flight");

  // A full answer carries no handle.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == gha_pkg::STATUS_FULL) |->
      (out_data.handle_index == '0) && (out_data.handle_version == '0) &&
      !out_data.handle_valid)
    else $error("full status with a handle");

  // No result is presented in the cycle after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind generational_handle_allocator_core gha_checker u_gha_checker (.*);

// File: tb/sv/tb.sv
// Self-checking testbench for the generational handle allocator core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gha_pkg::*;

  localparam int SLOT_TOTAL  = 1024;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_AFTER   = 450;
  localparam int HOLD_CYCLES  = 120;

  // The fourth opcode has no name in the package; it behaves as a check that reports an error.
  localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;

  logic     clk;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  request_t in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  result_t  out_data;

  generational_handle_allocator_core #(
    .SLOT_COUNT  (SLOT_TOTAL),
    .VERSION_BITS(16)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Shadow copy of the allocator state, updated in acceptance order.
  logic [15:0] ver_model [SLOT_TOTAL] = '{default: '0};
  logic        free_model [SLOT_TOTAL] = '{default: 1'b0};
  int          hw_model = 0;
  int          full_answers = 0;

  result_t pending_answers [$];
  int      fail_count = 0;
  int      answers_seen = 0;
  int      cycle_count = 0;
  int      snd_idle_pct = 36;
  int      rcv_idle_pct = 82;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  result_t due;

  // One row of the directed sequence; known rows carry a hand-written answer.
  typedef struct {
    request_t req;
    logic     known;
    result_t  answer;
  } plan_row_t;

  plan_row_t directed_plan [24] = '{
    // Empty allocator: nothing is opened yet.
    '{ {OP_CHECK,    10'd0,    16'd0},      1'b1, {STATUS_OK,   10'd0,    16'd0, 1'b0} },
    '{ {OP_RELEASE,  10'd1023, 16'hFFFF},   1'b1, {STATUS_BAD,  10'd1023, 16'd0, 1'b0} },
    '{ {OP_RESERVED, 10'd5,    16'd0},      1'b1, {STATUS_BAD,  10'd5,    16'd0, 1'b0} },
    // Fresh slots open in order at version zero.
    '{ {OP_ALLOC,    10'd0,    16'd0},      1'b1, {STATUS_OK,   10'd0,    16'd0, 1'b1} },
    '{ {OP_ALLOC,    10'd1023, 16'hFFFF},   1'b1, {STATUS_OK,   10'd1,    16'd0, 1'b1} },
    '{ {OP_ALLOC,    10'd0,    16'd0},      1'b1, {STATUS_OK,   10'd2,    16'd0, 1'b1} },
    '{ {OP_CHECK,    10'd1,    16'd0},      1'b0, '0 },
    '{ {OP_CHECK,    10'd1,    16'hFFFF},   1'b0, '0 },
    '{ {OP_RELEASE,  10'd1,    16'd0},      1'b0, '0 },
    // Release of a free slot is refused even with a matching version.
    '{ {OP_RELEASE,  10'd1,    16'd1},      1'b1, {STATUS_BAD,  10'd1,    16'd1, 1'b1} },
    '{ {OP_CHECK,    10'd1,    16'd1},      1'b0, '0 },
    '{ {OP_RELEASE,  10'd1,    16'd0},      1'b1, {STATUS_BAD,  10'd1,    16'd1, 1'b0} },
    '{ {OP_RELEASE,  10'd0,    16'd0},      1'b0, '0 },
    // Reuse picks the highest free slot first.
    '{ {OP_ALLOC,    10'd0,    16'd0},      1'b0, '0 },
    '{ {OP_ALLOC,    10'd0,    16'd0},      1'b0, '0 },
    '{ {OP_ALLOC,    10'd0,    16'd0},      1'b0, '0 },
    '{ {OP_CHECK,    10'd4,    16'd0},      1'b1, {STATUS_OK,   10'd4,    16'd0, 1'b0} },
    '{ {OP_RELEASE,  10'd2,    16'h8000},   1'b1, {STATUS_BAD,  10'd2,    16'd0, 1'b0} },
    '{ {OP_CHECK,    10'd1023, 16'hFFFF},   1'b1, {STATUS_OK,   10'd1023, 16'd0, 1'b0} },
    '{ {OP_RESERVED, 10'd2,    16'd0},      1'b1, {STATUS_BAD,  10'd2,    16'd0, 1'b1} },
    '{ {OP_RELEASE,  10'd3,    16'd0},      1'b0, '0 },
    '{ {OP_RELEASE,  10'd2,    16'd0},      1'b0, '0 },
    '{ {OP_ALLOC,    10'd0,    16'd0},      1'b0, '0 },
    '{ {OP_RESERVED, 10'd3,    16'd1},      1'b0, '0 }
  };

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Computes the answer to one request and advances the shadow state.
  function automatic result_t allocator_answer(input request_t r);
    result_t     a;
    int          pick;
    logic [15:0] stored;
    logic        opened;
    logic        match;
    a = '0;
    if (r.opcode == OP_ALLOC) begin
      // The highest-numbered free slot wins; otherwise open a fresh one.
      pick = -1;
      for (int k = 0; k < hw_model; k++) begin
        if (free_model[k]) begin
          pick = k;
        end
      end
      if (pick >= 0) begin
        free_model[pick] = 1'b0;
        a.handle_index   = 10'(pick);
        a.handle_version = ver_model[pick];
        a.handle_valid   = 1'b1;
      end else if (hw_model < SLOT_TOTAL) begin
        ver_model[hw_model] = '0;
        a.handle_index      = 10'(hw_model);
        a.handle_valid      = 1'b1;
        hw_model++;
      end else begin
        a.status = STATUS_FULL;
        full_answers++;
      end
    end else begin
      opened = r.slot_index < hw_model;
      stored = opened ? ver_model[r.slot_index] : '0;
      match  = opened && (stored == r.slot_version);
      a.handle_index   = r.slot_index;
      a.handle_version = stored;
      a.handle_valid   = match;
      case (r.opcode)
        OP_RELEASE: begin
          if (!match || free_model[r.slot_index]) begin
            a.status = STATUS_BAD;
          end else begin
            ver_model[r.slot_index]  = stored + 16'd1;
            free_model[r.slot_index] = 1'b1;
          end
        end
        OP_CHECK: a.status = STATUS_OK;
        default:  a.status = STATUS_BAD;
      endcase
    end
    return a;
  endfunction

  // Builds a random request: mostly live handles, with stale versions and noise mixed in.
  function automatic request_t pick_request(input int alloc_pct);
    request_t r;
    int       roll;
    int       rest;
    int       shape;
    r.opcode       = OP_ALLOC;
    r.slot_index   = 10'($urandom);
    r.slot_version = 16'($urandom);
    roll = $urandom_range(0, 99);
    rest = 98 - alloc_pct;
    if (roll >= 98) begin
      r.opcode = OP_RESERVED;
    end else if (roll >= alloc_pct + rest * 55 / 100) begin
      r.opcode = OP_CHECK;
    end else if (roll >= alloc_pct) begin
      r.opcode = OP_RELEASE;
    end
    if (r.opcode != OP_ALLOC && hw_model > 0) begin
      shape = $urandom_range(0, 9);
      if (shape < 8) begin
        r.slot_index = 10'($urandom_range(0, hw_model - 1));
        // Releases prefer a slot that is still in use.
        for (int k = 0; k < 6 && r.opcode == OP_RELEASE && free_model[r.slot_index]; k++) begin
          r.slot_index = 10'($urandom_range(0, hw_model - 1));
        end
        r.slot_version = ver_model[r.slot_index];
        if (shape == 7) begin
          r.slot_version = r.slot_version - 16'd1;
        end
      end else if (shape == 8) begin
        r.slot_index = 10'($urandom_range(0, hw_model - 1));
      end
    end
    return r;
  endfunction

  // Offers one transaction, waits for acceptance and queues its expected answer.
  task automatic offer_request(input request_t r, input logic known, input result_t known_answer);
    result_t a;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    a = allocator_answer(r);
    pending_answers.insert(pending_answers.size(), known ? known_answer : a);
  endtask

  // Holds the input idle until every queued answer has come back.
  task automatic drain_answers();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Stimulus sequence.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      offer_request(directed_plan[i].req, directed_plan[i].known, directed_plan[i].answer);
    end
    for (int n = 0; n < 60; n++) begin
      offer_request(pick_request(70), 1'b0, '0);
    end
    drain_answers();

    snd_idle_pct = 82;
    rcv_idle_pct = 36;
    for (int n = 0; n < 60; n++) begin
      offer_request(pick_request(70), 1'b0, '0);
    end
    drain_answers();

    // Back to back: fill every slot until the allocator reports full a few times.
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    while (full_answers < 4) begin
      offer_request(pick_request(96), 1'b0, '0);
    end
    for (int n = 0; n < 30; n++) begin
      offer_request(pick_request(50), 1'b0, '0);
    end
    drain_answers();

    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Result side: check each transaction and drive the stall pattern.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        answers_seen++;
        if (pending_answers.size() == 0) begin
          $error("result transaction with no request pending");
          fail_count++;
        end else begin
          due = pending_answers.pop_front();
          if (out_data.status !== due.status) begin
            $error("status: expected %0d, actual %0d", due.status, out_data.status);
            fail_count++;
          end
          if (out_data.handle_index !== due.handle_index) begin
            $error("handle_index: expected %0d, actual %0d",
                   due.handle_index, out_data.handle_index);
            fail_count++;
          end
          if (out_data.handle_version !== due.handle_version) begin
            $error("handle_version: expected %0d, actual %0d",
                   due.handle_version, out_data.handle_version);
            fail_count++;
          end
          if (out_data.handle_valid !== due.handle_valid) begin
            $error("handle_valid: expected %0d, actual %0d",
                   due.handle_valid, out_data.handle_valid);
            fail_count++;
          end
        end
      end
      // One long hold-off during the back-to-back phase lets the block back up.
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && answers_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: done, errors");
      $finish;
    end
  end

endmodule

// File: sim.f
rtl/gha_pkg.sv
rtl/gha_free_map.sv
rtl/generational_handle_allocator_core.sv
rtl/gha_checker.sv
tb/sv/tb.sv
